FILE: src/kwm_pkg.sv
// kwm_pkg: shared widths, command and status codes, and the word types
// that pass between the front end, the merge engine and the top level
// no dependencies
package kwm_pkg;

   localparam int CMD_W    = 2;
   localparam int IDX_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   localparam int NUM_LISTS_DEFAULT  = 8;
   localparam int LIST_DEPTH_DEFAULT = 64;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef enum logic [2:0] {
      OP_PUSH  = 3'd0,
      OP_DROP  = 3'd1,
      OP_POP   = 3'd2,
      OP_CLEAR = 3'd3,
      OP_NOP   = 3'd4
   } op_kind_type;

   typedef struct packed {
      op_kind_type              kind;
      logic [IDX_W-1:0]         list;
      logic signed [VALUE_W-1:0] value;
   } op_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] popped_value;
      logic [IDX_W-1:0]          source_list;
   } rsp_type;

endpackage

FILE: src/kwm_fifo.sv
// kwm_fifo: small register-based word queue with full and empty flags
// depends on kwm_pkg for the default depth
module kwm_fifo
   import kwm_pkg::*;
#(
   parameter int WIDTH = 1,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         data_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: src/kwm_front.sv
// kwm_front: takes request words, classifies them into operations and
// queues them for the merge engine; depends on kwm_pkg and kwm_fifo
module kwm_front
   import kwm_pkg::*;
#(
   parameter int NUM_LISTS = NUM_LISTS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [CMD_W-1:0]          req_command,
   input  logic [IDX_W-1:0]          req_list_index,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      push,
   output logic                      full,
   input  logic                      op_pop,
   output op_type                    op_word,
   output logic                      op_empty
);

   op_type                   op_new;
   logic [$bits(op_type)-1:0] q_data;

   always_comb begin
      op_new.list  = req_list_index;
      op_new.value = req_value;
      case (req_command)
         CMD_PUSH: begin
            op_new.kind = (int'(req_list_index) >= NUM_LISTS) ? OP_DROP : OP_PUSH;
         end
         CMD_POP: begin
            op_new.kind = OP_POP;
         end
         CMD_CLEAR: begin
            op_new.kind = OP_CLEAR;
         end
         default: begin
            op_new.kind = OP_NOP;
         end
      endcase
   end

   kwm_fifo #(
      .WIDTH ($bits(op_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_op_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (op_new),
      .full    (full),
      .rd_en   (op_pop),
      .rd_data (q_data),
      .empty   (op_empty)
   );

   assign op_word = op_type'(q_data);

endmodule

FILE: src/kwm_back.sv
// kwm_back: merge engine with the list store, per-list head pointers and
// fill counts, the head scan and the result queue; depends on kwm_pkg, kwm_fifo
module kwm_back
   import kwm_pkg::*;
#(
   parameter int NUM_LISTS  = NUM_LISTS_DEFAULT,
   parameter int LIST_DEPTH = LIST_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  op_type  op_word,
   input  logic    op_empty,
   output logic    op_pop,
   output rsp_type rsp_word,
   output logic    rsp_empty,
   input  logic    rsp_pop
);

   localparam int LIST_W = $clog2(NUM_LISTS);
   localparam int PTR_W  = $clog2(LIST_DEPTH);
   localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
   localparam int ADDR_W = $clog2(NUM_LISTS * LIST_DEPTH);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_PUSH = 6'b000010,
      S_SCAN = 6'b000100,
      S_LAST = 6'b001000,
      S_POP  = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   state_type                 state_ff, state_in;
   op_type                    op_ff, op_in;
   rsp_type                   res_ff, res_in;
   logic [LIST_W-1:0]         sel_ff, sel_in;
   logic                      scan_valid_ff, scan_valid_in;
   logic [LIST_W-1:0]         scan_list_ff, scan_list_in;
   logic                      found_ff, found_in;
   logic [LIST_W-1:0]         best_list_ff, best_list_in;
   logic signed [VALUE_W-1:0] best_val_ff, best_val_in;

   logic [PTR_W-1:0]          rp_ff [NUM_LISTS];
   logic [CNT_W-1:0]          fill_ff [NUM_LISTS];
   logic signed [VALUE_W-1:0] mem [NUM_LISTS * LIST_DEPTH];
   logic signed [VALUE_W-1:0] rd_data_ff;

   logic [PTR_W-1:0]  cur_rp, rp_next, tail_slot;
   logic [CNT_W-1:0]  cur_fill;
   logic [CNT_W:0]    tail_sum;
   logic [ADDR_W-1:0] base, rd_addr, wr_addr;
   logic              is_full, take, start;
   logic              mem_we, rp_we, fill_we, clear_all;
   logic [PTR_W-1:0]  rp_wval;
   logic [CNT_W-1:0]  fill_wval;
   logic              rsp_full;
   logic [$bits(rsp_type)-1:0] rsp_data;

   assign cur_rp   = rp_ff[sel_ff];
   assign cur_fill = fill_ff[sel_ff];
   assign base     = ADDR_W'(sel_ff) * ADDR_W'(LIST_DEPTH);
   assign tail_sum = (CNT_W + 1)'(cur_rp) + (CNT_W + 1)'(cur_fill);
   assign tail_slot = (tail_sum >= (CNT_W + 1)'(LIST_DEPTH))
                      ? PTR_W'(tail_sum - (CNT_W + 1)'(LIST_DEPTH))
                      : PTR_W'(tail_sum);
   assign wr_addr  = base + ADDR_W'(tail_slot);
   assign rd_addr  = base + ADDR_W'(cur_rp);
   assign rp_next  = (cur_rp == PTR_W'(LIST_DEPTH - 1)) ? '0 : cur_rp + 1'b1;
   assign is_full  = (cur_fill == CNT_W'(LIST_DEPTH));
   assign take     = scan_valid_ff && (!found_ff || (rd_data_ff <= best_val_ff));
   assign start    = (state_ff == S_IDLE) && !op_empty && !rsp_full;
   assign op_pop   = start;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      res_in        = res_ff;
      sel_in        = sel_ff;
      scan_valid_in = 1'b0;
      scan_list_in  = scan_list_ff;
      found_in      = found_ff;
      best_list_in  = best_list_ff;
      best_val_in   = best_val_ff;
      mem_we        = 1'b0;
      rp_we         = 1'b0;
      fill_we       = 1'b0;
      clear_all     = 1'b0;
      rp_wval       = rp_next;
      fill_wval     = cur_fill;

      if (take) begin
         found_in     = 1'b1;
         best_list_in = scan_list_ff;
         best_val_in  = rd_data_ff;
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in              = op_word;
               res_in.status      = ST_OK;
               res_in.popped_value = '0;
               res_in.source_list = '0;
               case (op_word.kind)
                  OP_PUSH: begin
                     sel_in   = LIST_W'(op_word.list);
                     state_in = S_PUSH;
                  end
                  OP_POP: begin
                     sel_in   = '0;
                     found_in = 1'b0;
                     state_in = S_SCAN;
                  end
                  OP_DROP: begin
                     res_in.status = ST_FULL;
                     state_in      = S_DONE;
                  end
                  OP_CLEAR: begin
                     clear_all = 1'b1;
                     state_in  = S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_PUSH: begin
            if (is_full) begin
               res_in.status = ST_FULL;
            end else begin
               mem_we    = 1'b1;
               fill_we   = 1'b1;
               fill_wval = cur_fill + 1'b1;
            end
            state_in = S_DONE;
         end
         S_SCAN: begin
            scan_valid_in = (cur_fill != '0);
            scan_list_in  = sel_ff;
            if (sel_ff == LIST_W'(NUM_LISTS - 1)) begin
               state_in = S_LAST;
            end else begin
               sel_in = sel_ff + 1'b1;
            end
         end
         S_LAST: begin
            sel_in   = best_list_in;
            state_in = S_POP;
         end
         S_POP: begin
            if (!found_ff) begin
               res_in.status = ST_EMPTY;
            end else begin
               rp_we               = 1'b1;
               fill_we             = 1'b1;
               fill_wval           = cur_fill - 1'b1;
               res_in.popped_value = best_val_ff;
               res_in.source_list  = IDX_W'(best_list_ff);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         scan_valid_ff <= 1'b0;
         found_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_valid_ff <= scan_valid_in;
         found_ff      <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      res_ff       <= res_in;
      sel_ff       <= sel_in;
      scan_list_ff <= scan_list_in;
      best_list_ff <= best_list_in;
      best_val_ff  <= best_val_in;
   end

   // per-list head pointers and fill counts
   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         for (int i = 0; i < NUM_LISTS; i++) begin
            rp_ff[i]   <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         if (rp_we) begin
            rp_ff[sel_ff] <= rp_wval;
         end
         if (fill_we) begin
            fill_ff[sel_ff] <= fill_wval;
         end
      end
   end

   // list store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= op_ff.value;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   kwm_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (state_ff == S_DONE),
      .wr_data (res_ff),
      .full    (rsp_full),
      .rd_en   (rsp_pop),
      .rd_data (rsp_data),
      .empty   (rsp_empty)
   );

   assign rsp_word = rsp_type'(rsp_data);

endmodule

FILE: src/k_way_sorted_merge.sv
// Merges up to NUM_LISTS sorted lists of LIST_DEPTH signed 32-bit words.
// A push word appends a value to one list, a pop word returns the smallest
// head (highest list index on ties) and a clear word empties every list;
// each request word gives exactly one response word, in order. Requests are
// taken into a two-word queue and responses wait in a two-word queue, so
// both sides can stall on their own. The engine handles one word at a time;
// a pop is paced by the head scan, which reads one list head per cycle from
// the list store, which has one read port. No clearing pass is needed after
// reset. Depends on kwm_pkg, kwm_front, kwm_back and kwm_fifo.
module k_way_sorted_merge
   import kwm_pkg::*;
#(
   parameter int NUM_LISTS  = NUM_LISTS_DEFAULT,
   parameter int LIST_DEPTH = LIST_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [CMD_W-1:0]           req_command,
   input  logic [IDX_W-1:0]           req_list_index,
   input  logic signed [VALUE_W-1:0]  req_value,
   input  logic                       push,
   output logic                       full,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [VALUE_W-1:0]  rsp_popped_value,
   output logic [IDX_W-1:0]           rsp_source_list,
   output logic                       empty,
   input  logic                       pop
);

   op_type  op_word;
   logic    op_empty;
   logic    op_pop;
   rsp_type rsp_word;

   kwm_front #(
      .NUM_LISTS (NUM_LISTS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_command    (req_command),
      .req_list_index (req_list_index),
      .req_value      (req_value),
      .push           (push),
      .full           (full),
      .op_pop         (op_pop),
      .op_word        (op_word),
      .op_empty       (op_empty)
   );

   kwm_back #(
      .NUM_LISTS  (NUM_LISTS),
      .LIST_DEPTH (LIST_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .op_word   (op_word),
      .op_empty  (op_empty),
      .op_pop    (op_pop),
      .rsp_word  (rsp_word),
      .rsp_empty (empty),
      .rsp_pop   (pop)
   );

   assign rsp_status       = rsp_word.status;
   assign rsp_popped_value = rsp_word.popped_value;
   assign rsp_source_list  = rsp_word.source_list;

endmodule
